### design/cbd_pkg.sv
`default_nettype none
package cbd_pkg;

    localparam int CBD_SIZE_BITS = 31;
    localparam int CBD_BYTE_W    = 8;
    localparam int CBD_CNT_W     = 32;

    localparam logic [CBD_CNT_W-1:0] CBD_MAX_RESET = '1;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_LINE_START = 3'd0;
    localparam t_phase PH_BLANKS     = 3'd1;
    localparam t_phase PH_DIGITS     = 3'd2;
    localparam t_phase PH_LINE_REST  = 3'd3;
    localparam t_phase PH_PAYLOAD    = 3'd4;
    localparam t_phase PH_SKIP_END   = 3'd5;

    localparam logic [CBD_BYTE_W-1:0] ASCII_LF = 8'h0A;

    typedef struct packed {
        t_phase               phase;
        logic                 seen_hex;
        logic                 done;
        logic                 trunc;
        logic [CBD_CNT_W-1:0] total;
    } t_state;

    typedef struct packed {
        logic                  data_valid;
        logic [CBD_BYTE_W-1:0] payload_byte;
        logic                  body_complete;
        logic                  body_truncated;
        logic [CBD_CNT_W-1:0]  decoded_count;
    } t_result;

    function automatic logic is_blank(input logic [CBD_BYTE_W-1:0] c);
        return c inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
    endfunction

    function automatic logic is_hex(input logic [CBD_BYTE_W-1:0] c);
        return (c inside {[8'h30:8'h39]}) || (c inside {[8'h61:8'h66]})
            || (c inside {[8'h41:8'h46]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [CBD_BYTE_W-1:0] c);
        logic [3:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

### design/cbd_if.sv
`default_nettype none
interface cbd_in_if import cbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CBD_BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cbd_out_if import cbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  data_valid;
    logic [CBD_BYTE_W-1:0] payload_byte;
    logic                  body_complete;
    logic                  body_truncated;
    logic [CBD_CNT_W-1:0]  decoded_count;

    modport source (output valid, output data_valid, output payload_byte,
                    output body_complete, output body_truncated,
                    output decoded_count, input ready);
    modport sink   (input valid, input data_valid, input payload_byte,
                    input body_complete, input body_truncated,
                    input decoded_count, output ready);
endinterface
`default_nettype wire

### design/chunked_body_decoder.sv
// The result of a byte transferred in is registered and shown from the next cycle on.
// One byte per cycle unless a held result stalls; the parse state takes one step per byte.
// The output register keeps taking bytes while its held result is transferred out.
// Reset (synchronous, active low): size-line start, counters and flags cleared,
// max_body_length set to all ones, no result held.
`default_nettype none
module chunked_body_decoder import cbd_pkg::*; #(
    parameter int SIZE_BITS = CBD_SIZE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CBD_CNT_W-1:0] i_cfg_wdata,
    cbd_in_if.sink                    i_in,
    cbd_out_if.source                 o_out
);

    logic [CBD_CNT_W-1:0]  r_max_len;
    t_state                r_st;
    t_state                n_st;
    logic [SIZE_BITS-1:0]  r_chunk;
    logic [SIZE_BITS-1:0]  n_chunk;
    logic                  r_out_valid;
    t_result               r_res;
    t_result               n_res;
    logic                  in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    cbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_byte    (i_in.in_byte),
        .i_max_len (r_max_len),
        .i_st      (r_st),
        .i_chunk   (r_chunk),
        .o_st      (n_st),
        .o_chunk   (n_chunk),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= CBD_MAX_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase    <= PH_LINE_START;
            r_st.seen_hex <= 1'b0;
            r_st.done     <= 1'b0;
            r_st.trunc    <= 1'b0;
            r_st.total    <= '0;
            r_chunk       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_st        <= n_st;
                r_chunk     <= n_chunk;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.data_valid     = r_res.data_valid;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.body_complete  = r_res.body_complete;
    assign o_out.body_truncated = r_res.body_truncated;
    assign o_out.decoded_count  = r_res.decoded_count;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.done |=> r_st.done)
        else $error("body_complete cleared after being set");

    a_trunc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.trunc |-> r_st.done)
        else $error("truncated without complete");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("transfer in left no result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_res.data_valid) |=> (r_st.total == $past(r_st.total) + 1'b1))
        else $error("payload byte did not advance count");

endmodule
`default_nettype wire

### design/cbd_step.sv
`default_nettype none
module cbd_step import cbd_pkg::*; #(
    parameter int SIZE_BITS = CBD_SIZE_BITS
) (
    input  wire logic [CBD_BYTE_W-1:0] i_byte,
    input  wire logic [CBD_CNT_W-1:0]  i_max_len,
    input  wire t_state                i_st,
    input  wire logic [SIZE_BITS-1:0]  i_chunk,
    output t_state                     o_st,
    output logic [SIZE_BITS-1:0]       o_chunk,
    output t_result                    o_res
);

    localparam logic [SIZE_BITS-1:0] CHUNK_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    logic                   lf;
    logic                   blank;
    logic                   hex;
    logic [3:0]             digit;
    logic [SIZE_BITS+3:0]   acc;
    logic [SIZE_BITS-1:0]   acc_sat;
    logic [SIZE_BITS-1:0]   first_digit;
    logic                   valid;

    assign lf          = (i_byte == ASCII_LF);
    assign blank       = is_blank(i_byte);
    assign hex         = is_hex(i_byte);
    assign digit       = hex_val(i_byte);
    assign acc         = {i_chunk, 4'b0000} | {{SIZE_BITS{1'b0}}, digit};
    assign acc_sat     = (acc[SIZE_BITS+3:SIZE_BITS] != 4'd0) ? {SIZE_BITS{1'b1}}
                                                              : acc[SIZE_BITS-1:0];
    assign first_digit = {{(SIZE_BITS-4){1'b0}}, digit};

    always_comb begin
        o_st    = i_st;
        o_chunk = i_chunk;
        valid   = 1'b0;
        if (!i_st.done) begin
            case (i_st.phase)
                PH_BLANKS, PH_DIGITS, PH_LINE_REST: begin
                    if (lf) begin
                        if (!i_st.seen_hex || i_chunk == '0) begin
                            o_st.done  = 1'b1;
                            o_st.phase = PH_LINE_START;
                        end else begin
                            o_st.phase = PH_PAYLOAD;
                        end
                        o_st.seen_hex = 1'b0;
                    end else if (i_st.phase == PH_BLANKS) begin
                        if (blank) begin
                            o_st.phase = PH_BLANKS;
                        end else if (hex) begin
                            o_chunk       = acc_sat;
                            o_st.seen_hex = 1'b1;
                            o_st.phase    = PH_DIGITS;
                        end else begin
                            o_st.phase = PH_LINE_REST;
                        end
                    end else if (i_st.phase == PH_DIGITS) begin
                        if (hex) begin
                            o_chunk       = acc_sat;
                            o_st.seen_hex = 1'b1;
                        end else begin
                            o_st.phase = PH_LINE_REST;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (i_st.total < i_max_len) begin
                        valid      = 1'b1;
                        o_st.total = i_st.total + 1'b1;
                        o_chunk    = i_chunk - 1'b1;
                        if (i_chunk == CHUNK_ONE) begin
                            o_st.phase = PH_SKIP_END;
                        end
                    end else begin
                        o_st.trunc = 1'b1;
                        o_st.done  = 1'b1;
                    end
                end
                PH_SKIP_END: begin
                    if (lf) begin
                        o_st.phase = PH_LINE_START;
                    end
                end
                default: begin
                    o_st.seen_hex = 1'b0;
                    o_chunk       = '0;
                    if (lf) begin
                        o_st.phase = PH_LINE_START;
                    end else if (blank) begin
                        o_st.phase = PH_BLANKS;
                    end else if (hex) begin
                        o_chunk       = first_digit;
                        o_st.seen_hex = 1'b1;
                        o_st.phase    = PH_DIGITS;
                    end else begin
                        o_st.phase = PH_LINE_REST;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res.data_valid     = valid;
        o_res.payload_byte   = valid ? i_byte : '0;
        o_res.body_complete  = o_st.done;
        o_res.body_truncated = o_st.trunc;
        o_res.decoded_count  = o_st.total;
    end

endmodule
`default_nettype wire

### test/chunked_body_decoder_tb.sv
module chunked_body_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbd_pkg::*;

    localparam int RUN_LIMIT  = 500000;
    localparam int BODY_ITEMS = 1650;
    localparam int CALM_FROM  = 1480;
    localparam int CFG_EVERY  = 400;

    localparam logic [7:0] ASCII_CR = 8'h0D;

    localparam logic [7:0] SIZE_LINE [9] = '{
        8'h0A, 8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C, "3", "z", 8'h0A
    };
    localparam logic [7:0] FIRST_BODY [10] = '{
        8'h00, 8'hFF, 8'h0A, 8'h0D, 8'h0A, "0", "1", 8'h0A, 8'h80, 8'h0A
    };

    typedef enum int {
        END_ZERO_SIZE,
        END_BLANK_LINE,
        END_NO_DIGIT,
        END_TRUNCATE
    } t_ending;

    class chunk_tracker;
        t_result                  pending[$];
        logic [CBD_CNT_W-1:0]     limit;
        t_phase                   ph;
        logic [CBD_SIZE_BITS-1:0] remaining;
        logic [CBD_CNT_W-1:0]     passed;
        bit                       seen_digit;
        bit                       done;
        bit                       trunc;
        int                       errors;

        function new();
            limit      = CBD_MAX_RESET;
            ph         = PH_LINE_START;
            remaining  = '0;
            passed     = '0;
            seen_digit = 1'b0;
            done       = 1'b0;
            trunc      = 1'b0;
            errors     = 0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
        endfunction

        function void add_nibble(int d);
            logic [63:0] top;
            top = (64'd1 << CBD_SIZE_BITS) - 64'd1;
            if (64'(remaining) > (top - 64'(d)) / 64'd16) begin
                remaining = top[CBD_SIZE_BITS-1:0];
            end else begin
                remaining = CBD_SIZE_BITS'(64'(remaining) * 64'd16 + 64'(d));
            end
            seen_digit = 1'b1;
        endfunction

        function void take_byte(logic [7:0] c);
            t_result r;
            int      dv;
            r = '0;
            if (c >= "0" && c <= "9") begin
                dv = c - "0";
            end else if (c >= "a" && c <= "f") begin
                dv = c - "a" + 10;
            end else if (c >= "A" && c <= "F") begin
                dv = c - "A" + 10;
            end else begin
                dv = -1;
            end
            if (!done) begin
                case (ph)
                    PH_BLANKS, PH_DIGITS, PH_LINE_REST: begin
                        if (c == ASCII_LF) begin
                            if (!seen_digit || remaining == '0) begin
                                done = 1'b1;
                                ph   = PH_LINE_START;
                            end else begin
                                ph = PH_PAYLOAD;
                            end
                            seen_digit = 1'b0;
                        end else if (ph == PH_BLANKS) begin
                            if (!is_space(c)) begin
                                if (dv >= 0) begin
                                    add_nibble(dv);
                                    ph = PH_DIGITS;
                                end else begin
                                    ph = PH_LINE_REST;
                                end
                            end
                        end else if (ph == PH_DIGITS) begin
                            if (dv >= 0) begin
                                add_nibble(dv);
                            end else begin
                                ph = PH_LINE_REST;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        if (passed < limit) begin
                            r.data_valid   = 1'b1;
                            r.payload_byte = c;
                            passed++;
                            remaining--;
                            if (remaining == '0) begin
                                ph = PH_SKIP_END;
                            end
                        end else begin
                            trunc = 1'b1;
                            done  = 1'b1;
                        end
                    end
                    PH_SKIP_END: begin
                        if (c == ASCII_LF) begin
                            ph = PH_LINE_START;
                        end
                    end
                    default: begin
                        seen_digit = 1'b0;
                        remaining  = '0;
                        if (c == ASCII_LF) begin
                            ph = PH_LINE_START;
                        end else if (is_space(c)) begin
                            ph = PH_BLANKS;
                        end else if (dv >= 0) begin
                            add_nibble(dv);
                            ph = PH_DIGITS;
                        end else begin
                            ph = PH_LINE_REST;
                        end
                    end
                endcase
            end
            r.body_complete  = done;
            r.body_truncated = trunc;
            r.decoded_count  = passed;
            pending.push_back(r);
        endfunction

        function void note_field(string what, logic [CBD_CNT_W-1:0] want,
                                 logic [CBD_CNT_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t %s: expected %0h actual %0h", $time, what, want, got);
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %0h", $time, got);
                return;
            end
            want = pending.pop_front();
            note_field("data_valid", want.data_valid, got.data_valid);
            note_field("payload_byte", want.payload_byte, got.payload_byte);
            note_field("body_complete", want.body_complete, got.body_complete);
            note_field("body_truncated", want.body_truncated, got.body_truncated);
            note_field("decoded_count", want.decoded_count, got.decoded_count);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CBD_CNT_W-1:0] i_cfg_wdata;

    cbd_in_if  in_if ();
    cbd_out_if out_if ();

    chunked_body_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    chunk_tracker board = new;
    t_result      out_seen;
    int           cycles = 0;
    int           sent = 0;
    bit           calm = 1'b0;
    bit           gappy = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                board.take_byte(in_if.in_byte);
            end
            if (out_if.valid && out_if.ready) begin
                out_seen = '{data_valid:     out_if.data_valid,
                             payload_byte:   out_if.payload_byte,
                             body_complete:  out_if.body_complete,
                             body_truncated: out_if.body_truncated,
                             decoded_count:  out_if.decoded_count};
                board.match_result(out_seen);
            end
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            out_if.ready <= 1'b1;
            if (calm) begin
                @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                if ($urandom_range(0, 2) == 0) begin
                    out_if.ready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0D;
            3:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == ASCII_LF) begin
            b = 8'h0B;
        end
        return b;
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10) begin
            return 8'("0" + v);
        end
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        if (gappy && !calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CBD_CNT_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.limit = v;
    endtask

    task automatic send_chunk();
        int n;
        int nd;
        if ($urandom_range(0, 7) == 0) begin
            put_byte(ASCII_LF);
        end
        repeat ($urandom_range(0, 2)) put_byte(any_blank());
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
        repeat ($urandom_range(0, 2)) put_byte("0");
        nd = (n < 16) ? 1 : (n < 256) ? 2 : 3;
        for (int i = nd - 1; i >= 0; i--) begin
            put_byte(hex_char((n >> (4 * i)) & 15));
        end
        if ($urandom_range(0, 3) == 0) begin
            put_byte(";");
            repeat ($urandom_range(0, 5)) put_byte(line_byte());
        end else if ($urandom_range(0, 3) == 0) begin
            put_byte(any_blank());
        end
        if ($urandom_range(0, 3) != 0) begin
            put_byte(ASCII_CR);
        end
        put_byte(ASCII_LF);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) put_byte(line_byte());
        end
        put_byte(ASCII_CR);
        put_byte(ASCII_LF);
    endtask

    initial begin
        t_ending how;
        int      k;
        int      next_cfg;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // size lines never touch the limit, so parse one under a zero limit
        write_limit('0);
        foreach (SIZE_LINE[i]) put_byte(SIZE_LINE[i]);
        write_limit('1);
        foreach (FIRST_BODY[i]) put_byte(FIRST_BODY[i]);

        next_cfg = CFG_EVERY;
        while (sent < BODY_ITEMS) begin
            if (sent >= next_cfg) begin
                write_limit($urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                 : $urandom_range(32'h1000, 32'hFFFF_FFFE));
                next_cfg += CFG_EVERY;
            end
            calm  = (sent >= CALM_FROM);
            gappy = ($urandom_range(0, 3) != 0);
            send_chunk();
        end

        calm = 1'b1;
        how  = t_ending'($urandom_range(0, 3));
        case (how)
            END_TRUNCATE: begin
                k = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                write_limit((k == 0) ? '0 : board.passed + k);
                put_byte("7");
                repeat ($urandom_range(8, 10)) put_byte(hex_char($urandom_range(0, 15)));
                put_byte(ASCII_CR);
                put_byte(ASCII_LF);
                repeat (k + 3) put_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                write_limit('0);
                case (how)
                    END_ZERO_SIZE: begin
                        repeat ($urandom_range(1, 3)) put_byte("0");
                        put_byte(ASCII_CR);
                        put_byte(ASCII_LF);
                    end
                    END_BLANK_LINE: begin
                        repeat ($urandom_range(1, 3)) put_byte(any_blank());
                    end
                    default: begin
                        put_byte("g");
                        put_byte(";");
                    end
                endcase
                put_byte(ASCII_LF);
            end
        endcase
        // body is over: the rest must be dropped
        repeat (6) put_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (5) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
